// ----- rtl/mi4_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, types and index helpers for the 4x4 matrix inverse.
// No dependencies; every other file of the block uses this package.
package mi4_pkg;

  localparam int ELEM_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int IDX_W      = 4;
  localparam int NUM_ELEMS  = 16;

  // Wide operands are cut into limbs of the element width.
  localparam int LIMB_W     = ELEM_W;
  localparam int OPER_W     = LIMB_W + 1;
  localparam int PROD_W     = 2 * OPER_W;

  // Exact widths of the 2x2 minors, the adjugate and the determinant.
  localparam int MINOR_W    = 2 * ELEM_W + 1;
  localparam int ADJ_W      = 3 * ELEM_W + 1;
  localparam int DET_W      = 4 * ELEM_W + 2;
  localparam int DMAG_W     = DET_W - 1;

  // Divider: the quotient carries two bits beyond the element for saturation.
  localparam int NUM_W      = ADJ_W - 1 + 2 * FRAC_W;
  localparam int QUO_W      = ELEM_W + 2;
  localparam int DEN_W      = DMAG_W + QUO_W - 1;
  localparam int CNT_W      = $clog2(QUO_W);

  localparam int NUM_PAIRS  = 6;
  localparam int NUM_MINORS = 2 * NUM_PAIRS;
  localparam int MIN_IDX_W  = $clog2(NUM_MINORS);
  localparam int SHIFT_W    = 2;

  typedef struct packed {
    logic               valid;
    logic               clear;
    logic               neg;
    logic [SHIFT_W-1:0] shift;
  } mac_op_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     sat;
  } div_res_t;

  // Column pairs in order (0,1) (0,2) (0,3) (1,2) (1,3) (2,3).
  function automatic logic [1:0] pair_lo(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_hi(input logic [2:0] p);
    logic [1:0] r;
    case (p)
      3'd0:       r = 2'd1;
      3'd1, 3'd3: r = 2'd2;
      default:    r = 2'd3;
    endcase
    return r;
  endfunction

  // Pair made of the two columns that are neither a nor b.
  function automatic logic [2:0] pair_excl(input logic [1:0] a, input logic [1:0] b);
    logic [3:0] m;
    logic [2:0] r;
    m = (4'd1 << a) | (4'd1 << b);
    case (m)
      4'b1100: r = 3'd0;
      4'b1010: r = 3'd1;
      4'b0110: r = 3'd2;
      4'b1001: r = 3'd3;
      4'b0101: r = 3'd4;
      default: r = 3'd5;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/mi4_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for matrix elements in and inverse elements out.
// Depends on mi4_pkg for the payload widths.
interface mi4_in_if;
  logic                                valid;
  logic                                ready;
  logic [mi4_pkg::IDX_W-1:0]           element_index;
  logic signed [mi4_pkg::ELEM_W-1:0]   element_value;

  modport source (output valid, output element_index, output element_value, input ready);
  modport sink   (input valid, input element_index, input element_value, output ready);
endinterface

interface mi4_out_if;
  logic                                valid;
  logic                                ready;
  logic [mi4_pkg::IDX_W-1:0]           result_index;
  logic signed [mi4_pkg::ELEM_W-1:0]   result_value;
  logic                                singular;
  logic                                saturated;
  logic                                last_result;

  modport source (output valid, output result_index, output result_value, output singular,
                  output saturated, output last_result, input ready);
  modport sink   (input valid, input result_index, input result_value, input singular,
                  input saturated, input last_result, output ready);
endinterface

// ----- rtl/mi4_mac.sv -----
`timescale 1ns / 1ps
// Shared multiply-accumulate unit: one registered 33x33 product, then a wide
// accumulate with a limb shift. Depends on mi4_pkg.
module mi4_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mi4_pkg::mac_op_t                     op,
  input  logic signed [mi4_pkg::OPER_W-1:0]    a,
  input  logic signed [mi4_pkg::OPER_W-1:0]    b,
  output logic signed [mi4_pkg::DET_W-1:0]     acc
);
  import mi4_pkg::*;

  mac_op_t                   op_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [DET_W-1:0]   addend;
  logic signed [DET_W-1:0]   base;

  always_comb begin
    addend = DET_W'(prod_q);
    case (op_q.shift)
      2'd1:    addend = addend <<< LIMB_W;
      2'd2:    addend = addend <<< (2 * LIMB_W);
      default: addend = addend;
    endcase
    base = op_q.clear ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= '0;
    end else begin
      op_q <= op;
    end
    prod_q <= a * b;
    if (op_q.valid) begin
      acc <= op_q.neg ? base - addend : base + addend;
    end
  end

endmodule

// ----- rtl/mi4_div.sv -----
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle of adj * 2^(2*FRAC) by |det|,
// with signed saturation of the result. Depends on mi4_pkg.
module mi4_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [mi4_pkg::ADJ_W-1:0]    num,
  input  logic [mi4_pkg::DMAG_W-1:0]          dmag,
  input  logic                                det_neg,
  output logic                                done,
  output mi4_pkg::div_res_t                   res
);
  import mi4_pkg::*;

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [NUM_W-1:0]    rem;
  logic [DEN_W-1:0]    den;
  logic [QUO_W-1:0]    quo;
  logic                neg;
  logic [ADJ_W-1:0]    num_abs;
  logic                ge;
  logic                sat_pos;
  logic                sat_neg;

  assign num_abs = num[ADJ_W-1] ? ADJ_W'(-num) : ADJ_W'(num);
  assign ge      = (DEN_W'(rem) >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUO_W - 1);
        rem  <= {num_abs[ADJ_W-2:0], {(2 * FRAC_W){1'b0}}};
        den  <= {dmag, {(QUO_W - 1){1'b0}}};
        quo  <= '0;
        neg  <= num[ADJ_W-1] ^ det_neg;
      end else if (busy) begin
        if (ge) begin
          rem <= rem - den[NUM_W-1:0];
        end
        quo <= {quo[QUO_W-2:0], ge};
        den <= den >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sat_pos = |quo[QUO_W-1:ELEM_W-1];
  assign sat_neg = (|quo[QUO_W-1:ELEM_W]) | (quo[ELEM_W-1] & (|quo[ELEM_W-2:0]));

  always_comb begin
    if (neg) begin
      res.sat   = sat_neg;
      res.value = sat_neg ? {1'b1, {(ELEM_W - 1){1'b0}}} : -$signed(quo[ELEM_W-1:0]);
    end else begin
      res.sat   = sat_pos;
      res.value = sat_pos ? {1'b0, {(ELEM_W - 1){1'b1}}} : $signed(quo[ELEM_W-1:0]);
    end
  end

endmodule

// ----- rtl/matrix_inverse_4x4.sv -----
`timescale 1ns / 1ps
// 4x4 matrix inverse by exact adjugate and determinant, signed Q16.16 in and out.
// Loading takes one element request per cycle while idle; accepting index 15 starts a run to
// the last result: 132 products, each with reads of A and B and an issue on the one shared
// multiplier, plus write-back, then per result a read, the serial divider and hand-off.
// One run at a time; a singular matrix skips the divider.
// Reset (synchronous, active high) idles the sequencer; both stores hold no reset value.
module matrix_inverse_4x4 (
  input  logic         clk,
  input  logic         rst,
  mi4_in_if.sink       in_ch,
  mi4_out_if.source    out_ch
);
  import mi4_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_A, S_RD_B, S_MUL, S_FLUSH, S_WB,
    S_DIV_RD, S_DIV_GO, S_DIV_WAIT, S_OUT
  } state_t;

  typedef enum logic [1:0] {K_MIN, K_COF, K_DET} kind_t;

  state_t state;
  kind_t  kind;

  // Matrix store and adjugate store: synchronous memories with a registered read.
  logic signed [ELEM_W-1:0] mat_mem [NUM_ELEMS];
  logic signed [ADJ_W-1:0]  adj_mem [NUM_ELEMS];
  logic [IDX_W-1:0]         mat_raddr;
  logic signed [ELEM_W-1:0] mat_rdata;
  logic [IDX_W-1:0]         adj_raddr;
  logic signed [ADJ_W-1:0]  adj_rdata;
  logic                     adj_we;

  // The twelve 2x2 minors of rows 2,3 (first six) and rows 0,1 (last six).
  logic signed [MINOR_W-1:0] minor_reg [NUM_MINORS];

  // Sequencer counters: minor phase, cofactor phase, determinant phase, output.
  logic                 m_set;
  logic [2:0]           m_pair;
  logic                 m_term;
  logic [1:0]           c_row;
  logic [1:0]           c_col;
  logic [1:0]           c_k;
  logic                 c_limb;
  logic [1:0]           d_col;
  logic [1:0]           d_limb;
  logic [IDX_W-1:0]     o_idx;

  logic signed [OPER_W-1:0] opa;
  logic signed [OPER_W-1:0] opb;
  mac_op_t                  mac_op;
  logic signed [DET_W-1:0]  acc;
  logic [DET_W-1:0]         acc_abs;

  logic [DMAG_W-1:0]        dmag;
  logic                     det_neg;
  logic                     det_zero;
  logic                     div_start;
  logic                     div_done;
  div_res_t                 div_res;

  logic                     out_valid;
  logic [IDX_W-1:0]         out_index;
  logic signed [ELEM_W-1:0] out_value;
  logic                     out_sing;
  logic                     out_sat;
  logic                     out_last;

  logic                     in_acc;
  logic                     out_acc;
  logic                     grp_last;

  // Address and operand selection.
  logic [1:0]           min_ra;
  logic [1:0]           min_rb;
  logic [1:0]           j1;
  logic [1:0]           j2;
  logic [1:0]           cof_col;
  logic [MIN_IDX_W-1:0] minor_idx;
  logic signed [MINOR_W-1:0] cof_minor;
  logic [IDX_W-1:0]     addr_a;
  logic [IDX_W-1:0]     addr_b;

  assign in_acc  = in_ch.valid & in_ch.ready;
  assign out_acc = out_valid & out_ch.ready;

  always_comb begin
    min_ra    = m_set ? 2'd0 : 2'd2;
    min_rb    = m_set ? 2'd1 : 2'd3;
    j1        = pair_lo(m_pair);
    j2        = pair_hi(m_pair);
    // Column of the k-th term: the k-th column that is not the cofactor's column.
    cof_col   = (c_k < c_col) ? c_k : c_k + 2'd1;
    // Rows 0,1 expand along the other of the two against rows 2,3, and vice versa.
    minor_idx = c_row[1] ? MIN_IDX_W'(pair_excl(c_col, cof_col)) + MIN_IDX_W'(NUM_PAIRS)
                         : MIN_IDX_W'(pair_excl(c_col, cof_col));
    cof_minor = minor_reg[minor_idx];

    case (kind)
      K_MIN:   addr_a = {min_ra, m_term ? j2 : j1};
      K_COF:   addr_a = {c_row ^ 2'd1, cof_col};
      default: addr_a = {2'd0, d_col};
    endcase
    addr_b    = {min_rb, m_term ? j1 : j2};
    mat_raddr = (state == S_RD_B) ? addr_b : addr_a;
    adj_raddr = (state == S_DIV_RD) ? o_idx : {d_col, 2'b00};

    case (kind)
      K_MIN: begin
        opb          = OPER_W'(mat_rdata);
        mac_op.clear = ~m_term;
        mac_op.neg   = m_term;
        mac_op.shift = '0;
        grp_last     = m_term;
      end
      K_COF: begin
        opb          = c_limb ? $signed(cof_minor[MINOR_W-1:LIMB_W])
                              : $signed({1'b0, cof_minor[LIMB_W-1:0]});
        mac_op.clear = (c_k == 2'd0) & ~c_limb;
        mac_op.neg   = c_k[0] ^ c_row[0] ^ c_col[0];
        mac_op.shift = {1'b0, c_limb};
        grp_last     = (c_k == 2'd2) & c_limb;
      end
      default: begin
        case (d_limb)
          2'd0:    opb = $signed({1'b0, adj_rdata[LIMB_W-1:0]});
          2'd1:    opb = $signed({1'b0, adj_rdata[2*LIMB_W-1:LIMB_W]});
          default: opb = $signed(adj_rdata[ADJ_W-1:2*LIMB_W]);
        endcase
        mac_op.clear = (d_col == 2'd0) & (d_limb == 2'd0);
        mac_op.neg   = 1'b0;
        mac_op.shift = d_limb;
        grp_last     = (d_col == 2'd3) & (d_limb == 2'd2);
      end
    endcase
    mac_op.valid = (state == S_MUL);

    adj_we    = (state == S_WB) & (kind == K_COF);
    div_start = (state == S_DIV_GO) & ~det_zero;
    acc_abs   = acc[DET_W-1] ? DET_W'(-acc) : DET_W'(acc);
  end

  // Matrix store: written by element requests, read by the sequencer.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mat_mem[in_ch.element_index] <= in_ch.element_value;
    end
    mat_rdata <= mat_mem[mat_raddr];
  end

  // Adjugate store: cofactor c at row r lands transposed at c*4+r.
  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[{c_col, c_row}] <= acc[ADJ_W-1:0];
    end
    adj_rdata <= adj_mem[adj_raddr];
  end

  mi4_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mac_op),
    .a   (opa),
    .b   (opb),
    .acc (acc)
  );

  mi4_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .num     (adj_rdata),
    .dmag    (dmag),
    .det_neg (det_neg),
    .done    (div_done),
    .res     (div_res)
  );

  // Sequencer. Each product reads operand A, then operand B, then issues to the
  // multiplier; a group of products ends with a flush cycle and a write-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc && (in_ch.element_index == IDX_W'(NUM_ELEMS - 1))) begin
            kind   <= K_MIN;
            m_set  <= 1'b0;
            m_pair <= '0;
            m_term <= 1'b0;
            state  <= S_RD_A;
          end
        end
        S_RD_A: begin
          state <= S_RD_B;
        end
        S_RD_B: begin
          opa   <= OPER_W'(mat_rdata);
          state <= S_MUL;
        end
        S_MUL: begin
          case (kind)
            K_MIN: m_term <= ~m_term;
            K_COF: begin
              if (c_limb) begin
                c_limb <= 1'b0;
                c_k    <= (c_k == 2'd2) ? 2'd0 : c_k + 2'd1;
              end else begin
                c_limb <= 1'b1;
              end
            end
            default: begin
              if (d_limb == 2'd2) begin
                d_limb <= '0;
                d_col  <= d_col + 2'd1;
              end else begin
                d_limb <= d_limb + 2'd1;
              end
            end
          endcase
          state <= grp_last ? S_FLUSH : S_RD_A;
        end
        S_FLUSH: begin
          state <= S_WB;
        end
        S_WB: begin
          case (kind)
            K_MIN: begin
              minor_reg[m_set ? MIN_IDX_W'(m_pair) + MIN_IDX_W'(NUM_PAIRS)
                              : MIN_IDX_W'(m_pair)] <= acc[MINOR_W-1:0];
              state <= S_RD_A;
              if (m_pair == 3'(NUM_PAIRS - 1)) begin
                m_pair <= '0;
                if (m_set) begin
                  kind   <= K_COF;
                  c_row  <= '0;
                  c_col  <= '0;
                  c_k    <= '0;
                  c_limb <= 1'b0;
                end
                m_set <= ~m_set;
              end else begin
                m_pair <= m_pair + 3'd1;
              end
            end
            K_COF: begin
              state <= S_RD_A;
              c_col <= c_col + 2'd1;
              if (c_col == 2'd3) begin
                c_row <= c_row + 2'd1;
                if (c_row == 2'd3) begin
                  kind   <= K_DET;
                  d_col  <= '0;
                  d_limb <= '0;
                end
              end
            end
            default: begin
              det_neg  <= acc[DET_W-1];
              det_zero <= (acc == '0);
              dmag     <= acc_abs[DMAG_W-1:0];
              o_idx    <= '0;
              state    <= S_DIV_RD;
            end
          endcase
        end
        S_DIV_RD: begin
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          if (det_zero) begin
            out_valid <= 1'b1;
            out_index <= o_idx;
            out_value <= '0;
            out_sing  <= 1'b1;
            out_sat   <= 1'b0;
            out_last  <= (o_idx == IDX_W'(NUM_ELEMS - 1));
            state     <= S_OUT;
          end else begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            out_valid <= 1'b1;
            out_index <= o_idx;
            out_value <= div_res.value;
            out_sing  <= 1'b0;
            out_sat   <= div_res.sat;
            out_last  <= (o_idx == IDX_W'(NUM_ELEMS - 1));
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            out_valid <= 1'b0;
            if (o_idx == IDX_W'(NUM_ELEMS - 1)) begin
              state <= S_IDLE;
            end else begin
              o_idx <= o_idx + 1'b1;
              state <= S_DIV_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state == S_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.result_index = out_index;
  assign out_ch.result_value = out_value;
  assign out_ch.singular     = out_sing;
  assign out_ch.saturated    = out_sat;
  assign out_ch.last_result  = out_last;

  // A run never overlaps the loading of the next matrix.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a result is pending");

  // A singular run gives plain zeros, never a clipped value.
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.singular) |-> (out_ch.result_value == '0 && !out_ch.saturated))
    else $error("singular result carries a value");

  // The start element closes the input until the run is done.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.element_index == IDX_W'(NUM_ELEMS - 1)) |=> !in_ch.ready)
    else $error("input still open after the start element");

  // Taking the last result returns the block to loading.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (out_acc && out_ch.last_result) |=> in_ch.ready)
    else $error("block not idle after the last result");

endmodule
